### rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked at every rising edge outside reset
`define IAFP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("iafp assertion failed");
// checked at every rising edge, reset included
`define IAFP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("iafp assertion failed");
`else
`define IAFP_ASSERT(label, clk, rst, prop)
`define IAFP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### rtl/iafp_pkg.sv
// shared types, constants and the angle conversion of the frame parser
package iafp_pkg;

   localparam int FRAME_LEN = 11;
   localparam int COUNT_W   = $clog2(FRAME_LEN);

   localparam logic [7:0] HEAD_BYTE  = 8'h55;
   localparam logic [7:0] TYPE_MASK  = 8'h50;
   localparam logic [7:0] ANGLE_TYPE = 8'h53;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [FRAME_LEN-1:0][7:0] window_type;
   typedef logic signed [16:0] angle_type;

   typedef enum logic [1:0] {
      STAT_ANGLE  = 2'd0,
      STAT_OTHER  = 2'd1,
      STAT_REJECT = 2'd2
   } status_type;

   // verdict on the window, from the checker to the window store
   typedef struct packed {
      logic full;
      logic ok;
      logic is_angle;
   } check_type;

   // floor(s * 180 / 128) as shifts and adds: 180 = 128 + 32 + 16 + 4
   function automatic angle_type angle_of(input logic [7:0] lo, input logic [7:0] hi);
      logic signed [23:0] s;
      logic signed [23:0] prod;
      s    = 24'(signed'({hi, lo}));
      prod = (s <<< 7) + (s <<< 5) + (s <<< 4) + (s <<< 2);
      return prod[23:7];
   endfunction

endpackage

### rtl/iafp_window.sv
// eleven-byte receive window with fill count, write and drop-oldest shift
`include "assert_macros.svh"

module iafp_window
   import iafp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [7:0] wr_byte,
   input  check_type  verdict,
   output window_type merged,
   output logic       full
);

   window_type window_ff, window_in;
   count_type  count_ff, count_in;

   // window as it stands with the incoming word in place
   always_comb begin
      for (int i = 0; i < FRAME_LEN; i++) begin
         merged[i] = (count_ff == COUNT_W'(i)) ? wr_byte : window_ff[i];
      end
   end

   assign full = (count_ff == COUNT_W'(FRAME_LEN - 1));

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      if (wr_en) begin
         if (!full) begin
            window_in = merged;
            count_in  = count_ff + COUNT_W'(1);
         end else if (verdict.ok) begin
            count_in = '0;
         end else begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
               window_in[i] = merged[i + 1];
            end
            count_in = COUNT_W'(FRAME_LEN - 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `IAFP_ASSERT(a_count_range, clock, reset, count_ff <= COUNT_W'(FRAME_LEN - 1))
   `IAFP_ASSERT(a_reject_keeps_ten, clock, reset, (wr_en && full && !verdict.ok) |=> (count_ff == COUNT_W'(FRAME_LEN - 1)))
   `IAFP_ASSERT(a_frame_empties, clock, reset, (wr_en && full && verdict.ok) |=> (count_ff == '0))

endmodule

### rtl/iafp_check.sv
// header, type and checksum test of a full window, plus angle decode
module iafp_check
   import iafp_pkg::*;
(
   input  window_type merged,
   input  logic       full,
   output check_type  verdict,
   output angle_type  roll,
   output angle_type  pitch,
   output angle_type  yaw
);

   logic [7:0] s01, s23, s45, s67, s89, sa, sb, sum;

   // balanced tree over bytes 0 to 9, modulo 256
   assign s01 = merged[0] + merged[1];
   assign s23 = merged[2] + merged[3];
   assign s45 = merged[4] + merged[5];
   assign s67 = merged[6] + merged[7];
   assign s89 = merged[8] + merged[9];
   assign sa  = s01 + s23;
   assign sb  = s45 + s67;
   assign sum = sa + sb + s89;

   assign verdict.full     = full;
   assign verdict.ok       = (merged[0] == HEAD_BYTE) &&
                             ((merged[1] & TYPE_MASK) == TYPE_MASK) &&
                             (sum == merged[FRAME_LEN - 1]);
   assign verdict.is_angle = (merged[1] == ANGLE_TYPE);

   assign roll  = angle_of(merged[2], merged[3]);
   assign pitch = angle_of(merged[4], merged[5]);
   assign yaw   = angle_of(merged[6], merged[7]);

endmodule

### rtl/imu_angle_frame_parser.sv
// top level of the eleven-byte angle frame parser
// a byte passes through the input register, then the result register, to reach a result word
// throughput: one byte a cycle while no result word is stalled; window write, check and angle decode share one cycle
// a stalled result word holds the input register, so at most one byte waits inside
// bytes that do not complete a window give no result word
// reset clears the valid flags and the fill count; window bytes are not cleared
`include "assert_macros.svh"

module imu_angle_frame_parser
   import iafp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_frame_type,
   output logic signed [16:0] rsp_roll_deg,
   output logic signed [16:0] rsp_pitch_deg,
   output logic signed [16:0] rsp_yaw_deg
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic       rsp_valid_ff;
   status_type status_ff, status_in;
   logic [7:0] type_ff;
   angle_type  roll_ff, pitch_ff, yaw_ff, roll_in, pitch_in, yaw_in;

   // pipeline control
   logic       advance;
   logic       wr_en;

   // window and verdict
   window_type merged;
   logic       full;
   check_type  verdict;
   angle_type  roll, pitch, yaw;

   // the pipe moves unless a result word sits stalled at the output
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign wr_en     = in_valid_ff && advance;

   // the input register takes a word whenever it is not holding one back
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   iafp_window u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_byte (in_byte_ff),
      .verdict (verdict),
      .merged  (merged),
      .full    (full)
   );

   iafp_check u_check (
      .merged  (merged),
      .full    (full),
      .verdict (verdict),
      .roll    (roll),
      .pitch   (pitch),
      .yaw     (yaw)
   );

   // status and angle selection; angles read zero unless an angle frame passed
   always_comb begin
      status_in = STAT_REJECT;
      roll_in   = '0;
      pitch_in  = '0;
      yaw_in    = '0;
      if (verdict.ok) begin
         if (verdict.is_angle) begin
            status_in = STAT_ANGLE;
            roll_in   = roll;
            pitch_in  = pitch;
            yaw_in    = yaw;
         end else begin
            status_in = STAT_OTHER;
         end
      end
   end

   // result register, loaded only when a window fills
   always_ff @(posedge clock) begin
      if (wr_en && verdict.full) begin
         status_ff <= status_in;
         type_ff   <= merged[1];
         roll_ff   <= roll_in;
         pitch_ff  <= pitch_in;
         yaw_ff    <= yaw_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= wr_en && verdict.full;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_frame_type = type_ff;
   assign rsp_roll_deg   = roll_ff;
   assign rsp_pitch_deg  = pitch_ff;
   assign rsp_yaw_deg    = yaw_ff;

   `IAFP_ASSERT(a_angle_type, clock, reset, (rsp_valid_ff && status_ff == STAT_ANGLE) |-> (type_ff == ANGLE_TYPE))
   `IAFP_ASSERT(a_angles_zero, clock, reset, (rsp_valid_ff && status_ff != STAT_ANGLE) |-> (roll_ff == '0 && pitch_ff == '0 && yaw_ff == '0))
   `IAFP_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && !in_valid_ff))

endmodule
